FILE: rtl/core/dotq_pkg.sv
package dotq_pkg;

  // Default number of queue slots.
  localparam int unsigned DefSlots = 16;

  // At most this many entries fire on one tick.
  localparam int unsigned MaxFire = 16;
  localparam int unsigned FireW   = $clog2(MaxFire + 1);

  // Identifier counter range.
  localparam logic [30:0] IdStart = 31'd42;
  localparam logic [30:0] IdMax   = 31'h7FFF_FFFF;

  // Command codes carried on the request tuser.
  localparam logic [1:0] CmdPost   = 2'd0;
  localparam logic [1:0] CmdCancel = 2'd1;
  localparam logic [1:0] CmdTick   = 2'd2;

  // Result kinds carried on the result tuser.
  localparam logic [2:0] KindPosted    = 3'd0;
  localparam logic [2:0] KindDropped   = 3'd1;
  localparam logic [2:0] KindFull      = 3'd2;
  localparam logic [2:0] KindCancelled = 3'd3;
  localparam logic [2:0] KindNotFound  = 3'd4;
  localparam logic [2:0] KindFired     = 3'd5;
  localparam logic [2:0] KindNoneDue   = 3'd6;

  // One queue entry as held in the slot memory.
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] target;
    logic [30:0] id;
  } entry_t;

  // One result on its way to the output register.
  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] id;
    logic        last;
  } res_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StInsStart,
    StInsScan,
    StInsShift,
    StInsWr,
    StCanStart,
    StCanScan,
    StRmStart,
    StRmShift,
    StRmEnd,
    StTickRd,
    StTickChk,
    StResult
  } dotq_state_e;

endpackage

FILE: rtl/core/deadline_ordered_timer_queue_top.sv
// Timer event queue holding up to SLOTS entries sorted by deadline.
// Requests arrive on the s_axis channel: tuser selects post, cancel or tick,
// and tdata carries delay, period and the identifier to cancel. Results
// leave on the m_axis channel: tuser gives the result kind, tdata the event
// identifier and tlast marks the final result of a request.
// Post and cancel give one result each; a tick gives one result per fired
// entry (at most 16) or a single none-due result.
// One request is worked on at a time; s_axis_tready_o is high only while
// the sequencer is idle. Every scan and every shift of entries passes
// one slot per cycle through the single read and single write port of
// the slot memory.
// After reset the queue is empty, the time is zero and the next identifier
// is 42; no clearing pass is needed, as only slots below the fill count are
// ever used. When the receiver stalls, the result register holds its value
// and the sequencer waits with the next result until it is taken.
module deadline_ordered_timer_queue_top #(
  parameter int unsigned SLOTS = dotq_pkg::DefSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // [31:0] delay, [63:32] period,
                                        // [94:64] cancel_id, [95] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [30:0] event_id, [31] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned FW = dotq_pkg::FireW;

  // True when (int32)(a - b) > 0.
  function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return (diff != 32'd0) && !diff[31];
  endfunction

  // Sequencer and queue state.
  dotq_pkg::dotq_state_e state_q, state_d;
  logic [1:0]            cmd_q, cmd_d;
  logic [30:0]           cancel_id_q, cancel_id_d;
  dotq_pkg::entry_t      new_q, new_d;
  logic                  nd_q, nd_d;
  logic                  reins_q, reins_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         k_q, k_d;
  logic [CW-1:0]         p_q, p_d;
  logic [31:0]           time_q, time_d;
  logic [30:0]           id_ctr_q, id_ctr_d;
  logic [SLOTS-1:0]      done_q, done_d;
  logic [FW-1:0]         fire_cnt_q, fire_cnt_d;
  logic                  have_pend_q, have_pend_d;
  logic [30:0]           pend_id_q, pend_id_d;
  dotq_pkg::res_t        res_q, res_d;

  // Slot memory ports.
  dotq_pkg::entry_t mem_q [SLOTS];
  dotq_pkg::entry_t rd_q;
  dotq_pkg::entry_t wd;
  logic [IW-1:0]    ra, wa;
  logic             we;

  // Shared adder and deadline comparator.
  logic [31:0] add_b, sum;
  logic [31:0] cmp_b;
  logic        later;

  // Cursor arithmetic.
  logic [CW-1:0] k_inc, k_p2, k_dec, k_m2, p_inc, cnt_inc, cnt_dec;

  // Shifted copies of the fired-this-tick flags.
  logic [SLOTS-1:0] done_ins_sh, done_rm_sh;

  logic        in_acc;
  logic        push_valid, push_ready;
  logic        cont;
  logic [31:0] in_delay, in_period;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_delay  = s_axis_tdata_i[31:0];
  assign in_period = s_axis_tdata_i[63:32];

  assign s_axis_tready_o = (state_q == dotq_pkg::StIdle);

  assign sum   = time_q + add_b;
  assign later = is_later(rd_q.target, cmp_b);

  assign k_inc   = k_q + CW'(1);
  assign k_p2    = k_q + CW'(2);
  assign k_dec   = k_q - CW'(1);
  assign k_m2    = k_q - CW'(2);
  assign p_inc   = p_q + CW'(1);
  assign cnt_inc = cnt_q + CW'(1);
  assign cnt_dec = cnt_q - CW'(1);

  assign done_ins_sh = {done_q[SLOTS-2:0], 1'b0};
  assign done_rm_sh  = {1'b0, done_q[SLOTS-1:1]};

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cancel_id_d = cancel_id_q;
    new_d       = new_q;
    nd_d        = nd_q;
    reins_d     = reins_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    p_d         = p_q;
    time_d      = time_q;
    id_ctr_d    = id_ctr_q;
    done_d      = done_q;
    fire_cnt_d  = fire_cnt_q;
    have_pend_d = have_pend_q;
    pend_id_d   = pend_id_q;
    res_d       = res_q;
    we          = 1'b0;
    wa          = '0;
    wd          = new_q;
    ra          = '0;
    add_b       = 32'd1;
    cmp_b       = new_q.target;
    push_valid  = 1'b0;
    cont        = 1'b0;

    case (state_q)
      dotq_pkg::StIdle: begin
        if (in_acc) begin
          cmd_d       = s_axis_tuser_i;
          cancel_id_d = s_axis_tdata_i[94:64];
          case (s_axis_tuser_i)
            dotq_pkg::CmdPost: begin
              if (cnt_q == CW'(SLOTS)) begin
                res_d   = '{kind: dotq_pkg::KindFull, id: 31'd0, last: 1'b1};
                state_d = dotq_pkg::StResult;
              end else begin
                id_ctr_d = (id_ctr_q == dotq_pkg::IdMax) ? dotq_pkg::IdStart
                                                         : id_ctr_q + 31'd1;
                if (in_delay[31]) begin
                  res_d   = '{kind: dotq_pkg::KindDropped, id: id_ctr_q, last: 1'b1};
                  state_d = dotq_pkg::StResult;
                end else begin
                  add_b   = in_delay;
                  new_d   = '{period: in_period, target: sum, id: id_ctr_q};
                  nd_d    = 1'b0;
                  state_d = dotq_pkg::StInsStart;
                end
              end
            end
            dotq_pkg::CmdCancel: begin
              state_d = dotq_pkg::StCanStart;
            end
            dotq_pkg::CmdTick: begin
              add_b       = 32'd1;
              time_d      = sum;
              done_d      = '0;
              fire_cnt_d  = '0;
              have_pend_d = 1'b0;
              state_d     = dotq_pkg::StTickRd;
            end
            default: begin
              state_d = dotq_pkg::StIdle;
            end
          endcase
        end
      end

      // Insertion: find the first slot that is later than the new deadline.
      dotq_pkg::StInsStart: begin
        k_d = '0;
        if (cnt_q == '0) begin
          p_d     = '0;
          state_d = dotq_pkg::StInsWr;
        end else begin
          ra      = '0;
          state_d = dotq_pkg::StInsScan;
        end
      end

      dotq_pkg::StInsScan: begin
        cmp_b = new_q.target;
        if (later) begin
          p_d     = k_q;
          ra      = cnt_dec[IW-1:0];
          k_d     = cnt_q;
          state_d = dotq_pkg::StInsShift;
        end else if (k_inc == cnt_q) begin
          p_d     = cnt_q;
          state_d = dotq_pkg::StInsWr;
        end else begin
          ra  = k_inc[IW-1:0];
          k_d = k_inc;
        end
      end

      // Move entries one slot towards the tail, from the tail down.
      dotq_pkg::StInsShift: begin
        we = 1'b1;
        wa = k_q[IW-1:0];
        wd = rd_q;
        if (k_dec == p_q) begin
          state_d = dotq_pkg::StInsWr;
        end else begin
          ra  = k_m2[IW-1:0];
          k_d = k_dec;
        end
      end

      dotq_pkg::StInsWr: begin
        we    = 1'b1;
        wa    = p_q[IW-1:0];
        wd    = new_q;
        cnt_d = cnt_inc;
        for (int j = 0; j < SLOTS; j++) begin
          if (CW'(j) > p_q) begin
            done_d[j] = done_ins_sh[j];
          end else if (CW'(j) == p_q) begin
            done_d[j] = nd_q;
          end
        end
        if (cmd_q == dotq_pkg::CmdPost) begin
          res_d   = '{kind: dotq_pkg::KindPosted, id: new_q.id, last: 1'b1};
          state_d = dotq_pkg::StResult;
        end else begin
          state_d = dotq_pkg::StTickRd;
        end
      end

      // Cancel: search from the head for a matching identifier.
      dotq_pkg::StCanStart: begin
        k_d = '0;
        if (cnt_q == '0) begin
          res_d   = '{kind: dotq_pkg::KindNotFound, id: cancel_id_q, last: 1'b1};
          state_d = dotq_pkg::StResult;
        end else begin
          ra      = '0;
          state_d = dotq_pkg::StCanScan;
        end
      end

      dotq_pkg::StCanScan: begin
        if (rd_q.id == cancel_id_q) begin
          p_d     = k_q;
          state_d = dotq_pkg::StRmStart;
        end else if (k_inc == cnt_q) begin
          res_d   = '{kind: dotq_pkg::KindNotFound, id: cancel_id_q, last: 1'b1};
          state_d = dotq_pkg::StResult;
        end else begin
          ra  = k_inc[IW-1:0];
          k_d = k_inc;
        end
      end

      // Removal at slot p: move the entries behind it one slot forward.
      dotq_pkg::StRmStart: begin
        k_d = p_q;
        if (p_inc == cnt_q) begin
          state_d = dotq_pkg::StRmEnd;
        end else begin
          ra      = p_inc[IW-1:0];
          state_d = dotq_pkg::StRmShift;
        end
      end

      dotq_pkg::StRmShift: begin
        we = 1'b1;
        wa = k_q[IW-1:0];
        wd = rd_q;
        if (k_p2 == cnt_q) begin
          state_d = dotq_pkg::StRmEnd;
        end else begin
          ra  = k_p2[IW-1:0];
          k_d = k_inc;
        end
      end

      dotq_pkg::StRmEnd: begin
        cnt_d = cnt_dec;
        for (int j = 0; j < SLOTS; j++) begin
          if (CW'(j) >= p_q) begin
            done_d[j] = done_rm_sh[j];
          end
        end
        if (cmd_q == dotq_pkg::CmdCancel) begin
          res_d   = '{kind: dotq_pkg::KindCancelled, id: cancel_id_q, last: 1'b1};
          state_d = dotq_pkg::StResult;
        end else if (reins_q) begin
          state_d = dotq_pkg::StInsStart;
        end else begin
          state_d = dotq_pkg::StTickRd;
        end
      end

      // Tick: look at the head entry.
      dotq_pkg::StTickRd: begin
        ra      = '0;
        state_d = dotq_pkg::StTickChk;
      end

      dotq_pkg::StTickChk: begin
        cmp_b = time_q;
        cont  = (fire_cnt_q < FW'(dotq_pkg::MaxFire)) && (cnt_q != '0) &&
                !done_q[0] && !later;
        if (!cont) begin
          if (have_pend_q) begin
            res_d = '{kind: dotq_pkg::KindFired, id: pend_id_q, last: 1'b1};
          end else begin
            res_d = '{kind: dotq_pkg::KindNoneDue, id: 31'd0, last: 1'b1};
          end
          state_d = dotq_pkg::StResult;
        end else if (have_pend_q) begin
          // Another entry fires, so the one before it is not the last.
          res_d       = '{kind: dotq_pkg::KindFired, id: pend_id_q, last: 1'b0};
          have_pend_d = 1'b0;
          state_d     = dotq_pkg::StResult;
        end else begin
          pend_id_d   = rd_q.id;
          have_pend_d = 1'b1;
          fire_cnt_d  = fire_cnt_q + FW'(1);
          add_b       = rd_q.period;
          new_d       = '{period: rd_q.period, target: sum, id: rd_q.id};
          nd_d        = 1'b1;
          reins_d     = !rd_q.period[31];
          p_d         = '0;
          state_d     = dotq_pkg::StRmStart;
        end
      end

      // Hand one result to the output register.
      dotq_pkg::StResult: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_d = res_q.last ? dotq_pkg::StIdle : dotq_pkg::StTickRd;
        end
      end

      default: begin
        state_d = dotq_pkg::StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dotq_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      time_q      <= '0;
      id_ctr_q    <= dotq_pkg::IdStart;
      done_q      <= '0;
      fire_cnt_q  <= '0;
      have_pend_q <= 1'b0;
      cmd_q       <= dotq_pkg::CmdPost;
      reins_q     <= 1'b0;
      nd_q        <= 1'b0;
      k_q         <= '0;
      p_q         <= '0;
    end else begin
      cnt_q       <= cnt_d;
      time_q      <= time_d;
      id_ctr_q    <= id_ctr_d;
      done_q      <= done_d;
      fire_cnt_q  <= fire_cnt_d;
      have_pend_q <= have_pend_d;
      cmd_q       <= cmd_d;
      reins_q     <= reins_d;
      nd_q        <= nd_d;
      k_q         <= k_d;
      p_q         <= p_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cancel_id_q <= cancel_id_d;
    new_q       <= new_d;
    pend_id_q   <= pend_id_d;
    res_q       <= res_d;
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  dotq_outreg u_outreg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_valid_i    (push_valid),
    .push_res_i      (res_q),
    .push_ready_o    (push_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // A tick request advances the time by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == dotq_pkg::CmdTick) |=> time_q == $past(time_q) + 32'd1)
    else $error("tick did not advance the time by one");

  // A post into a queue with room always takes a fresh identifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == dotq_pkg::CmdPost && cnt_q != CW'(SLOTS))
      |=> id_ctr_q != $past(id_ctr_q))
    else $error("post did not advance the identifier counter");

  // The fill count never exceeds the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("fill count beyond slot count");

  // Results are only pushed from the result state, never while a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !push_valid)
    else $error("request taken while a result was pending");

endmodule

FILE: rtl/core/dotq_outreg.sv
module dotq_outreg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  dotq_pkg::res_t  push_res_i,
  output logic            push_ready_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [31:0]     m_axis_tdata_o,   // [30:0] event_id, [31] zero
  output logic [2:0]      m_axis_tuser_o,   // [2:0] kind
  output logic            m_axis_tlast_o
);

  logic           valid_q, valid_d;
  dotq_pkg::res_t res_q;

  // The register takes a new result when it is empty or being drained.
  assign push_ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_valid_i && push_ready_o) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      res_q <= push_res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q.id};
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last;

endmodule

FILE: test/timer_queue_monitor.sv
`timescale 1ns / 100ps

// Watches both channels of the timer queue, keeps its own copy of the queue
// state, works out the results of every accepted request and compares them
// with the results that the block delivers.
module timer_queue_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [95:0] s_axis_tdata_i,   // [31:0] delay, [63:32] period,
                                        // [94:64] cancel_id, [95] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [30:0] event_id, [31] zero
  input  logic [2:0]  m_axis_tuser_i,   // [2:0] kind
  input  logic        m_axis_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned Slots = dotq_pkg::DefSlots;

  // Shadow copy of the sorted slot store; valid entries form a prefix.
  logic [30:0] slot_id     [Slots];
  logic [31:0] slot_target [Slots];
  logic [31:0] slot_period [Slots];
  bit          slot_fired  [Slots];
  int unsigned fill;
  logic [31:0] tick_now;
  logic [30:0] next_id;

  // Results still owed by the block, oldest first.
  dotq_pkg::res_t owed_results_q [$];
  int unsigned    mismatches;

  // True when deadline a lies strictly after b on the wrapping time line.
  function automatic bit deadline_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return (diff != 32'd0) && !diff[31];
  endfunction

  // Removes the entry at idx and closes the gap.
  function automatic void drop_slot(int unsigned idx);
    for (int unsigned k = idx; k + 1 < fill; k++) begin
      slot_id[k]     = slot_id[k + 1];
      slot_target[k] = slot_target[k + 1];
      slot_period[k] = slot_period[k + 1];
      slot_fired[k]  = slot_fired[k + 1];
    end
    fill = fill - 1;
    slot_id[fill]     = '0;
    slot_target[fill] = '0;
    slot_period[fill] = '0;
    slot_fired[fill]  = 1'b0;
  endfunction

  // Inserts behind every entry whose deadline is not later than tgt.
  function automatic void place_slot(logic [30:0] id, logic [31:0] tgt,
                                     logic [31:0] per, bit fired);
    int unsigned pos;
    pos = 0;
    if (fill >= Slots) return;
    while (pos < fill && !deadline_after(slot_target[pos], tgt)) pos++;
    for (int unsigned k = fill; k > pos; k--) begin
      slot_id[k]     = slot_id[k - 1];
      slot_target[k] = slot_target[k - 1];
      slot_period[k] = slot_period[k - 1];
      slot_fired[k]  = slot_fired[k - 1];
    end
    slot_id[pos]     = id;
    slot_target[pos] = tgt;
    slot_period[pos] = per;
    slot_fired[pos]  = fired;
    fill = fill + 1;
  endfunction

  function automatic void owe_result(logic [2:0] kind, logic [30:0] id, logic last);
    dotq_pkg::res_t r;
    r.kind = kind;
    r.id   = id;
    r.last = last;
    owed_results_q.push_back(r);
  endfunction

  // Updates the shadow state for one request and queues what it must return.
  function automatic void timer_queue_apply(logic [1:0] cmd, logic [95:0] data);
    logic [31:0]    dly;
    logic [31:0]    per;
    logic [30:0]    cid;
    logic [30:0]    id;
    int unsigned    fired_cnt;
    bit             hit;
    dotq_pkg::res_t tail;
    dly = data[31:0];
    per = data[63:32];
    cid = data[94:64];
    case (cmd)
      dotq_pkg::CmdPost: begin
        if (fill >= Slots) begin
          owe_result(dotq_pkg::KindFull, '0, 1'b1);
        end else begin
          id = next_id;
          next_id = (id == dotq_pkg::IdMax) ? dotq_pkg::IdStart : id + 31'd1;
          if (dly[31]) begin
            owe_result(dotq_pkg::KindDropped, id, 1'b1);
          end else begin
            place_slot(id, tick_now + dly, per, 1'b0);
            owe_result(dotq_pkg::KindPosted, id, 1'b1);
          end
        end
      end
      dotq_pkg::CmdCancel: begin
        hit = 1'b0;
        for (int unsigned k = 0; k < fill && !hit; k++) begin
          if (slot_id[k] == cid) begin
            drop_slot(k);
            hit = 1'b1;
          end
        end
        owe_result(hit ? dotq_pkg::KindCancelled : dotq_pkg::KindNotFound, cid, 1'b1);
      end
      dotq_pkg::CmdTick: begin
        tick_now = tick_now + 32'd1;
        for (int unsigned k = 0; k < Slots; k++) slot_fired[k] = 1'b0;
        fired_cnt = 0;
        // Pop due entries from the head; requeued ones are marked so the
        // scan stops when it meets them again.
        while (fired_cnt < dotq_pkg::MaxFire && fill != 0 && !slot_fired[0] &&
               !deadline_after(slot_target[0], tick_now)) begin
          id  = slot_id[0];
          per = slot_period[0];
          drop_slot(0);
          if (!per[31]) place_slot(id, tick_now + per, per, 1'b1);
          owe_result(dotq_pkg::KindFired, id, 1'b0);
          fired_cnt++;
        end
        if (fired_cnt == 0) begin
          owe_result(dotq_pkg::KindNoneDue, '0, 1'b1);
        end else begin
          tail = owed_results_q.pop_back();
          tail.last = 1'b1;
          owed_results_q.push_back(tail);
        end
      end
      default: begin
        // The spare command code is ignored and returns nothing.
      end
    endcase
  endfunction

  // Compare delivered results first, then account for a new request.
  always @(posedge clk_i or negedge rst_ni) begin : compare_proc
    dotq_pkg::res_t want;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < Slots; k++) begin
        slot_id[k]     = '0;
        slot_target[k] = '0;
        slot_period[k] = '0;
        slot_fired[k]  = 1'b0;
      end
      fill       = 0;
      tick_now   = '0;
      next_id    = dotq_pkg::IdStart;
      mismatches = 0;
      owed_results_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (owed_results_q.size() == 0) begin
          $display("%0t: result with none owed, expected nothing, actual kind %0d id %0d",
                   $time, m_axis_tuser_i, m_axis_tdata_i);
          mismatches++;
        end else begin
          want = owed_results_q.pop_front();
          if (m_axis_tuser_i !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, m_axis_tuser_i);
            mismatches++;
          end
          if (m_axis_tdata_i !== {1'b0, want.id}) begin
            $display("%0t: event_id mismatch, expected %0d, actual %0d",
                     $time, {1'b0, want.id}, m_axis_tdata_i);
            mismatches++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $display("%0t: last mismatch, expected %0d, actual %0d",
                     $time, want.last, m_axis_tlast_i);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) timer_queue_apply(s_axis_tuser_i, s_axis_tdata_i);
      fail_count_o <= mismatches;
      pending_o    <= owed_results_q.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0]  CmdIgnored   = 2'd3;
  localparam int unsigned PhaseItems   = 80;
  localparam int unsigned HoldItems    = 20;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 300;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;   // [31:0] delay, [63:32] period,
                                     // [94:64] cancel_id, [95] zero
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [30:0] event_id, [31] zero
  logic [2:0]  m_axis_tuser;         // [2:0] kind
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_start     = 1'b0;
  int unsigned posts_sent     = 0;

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  deadline_ordered_timer_queue_top #(
    .SLOTS(dotq_pkg::DefSlots)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  timer_queue_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .m_axis_tlast_i (m_axis_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_start && !hold_taken) begin
        hold_left  = HoldCycles;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // is left high so that back-to-back requests need no extra edge.
  task automatic send_req(logic [1:0] cmd, logic [31:0] dly, logic [31:0] per,
                          logic [30:0] cid);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, cid, per, dly};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == dotq_pkg::CmdPost) posts_sent++;
  endtask

  // Stops offering and waits until every owed result has been delivered.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One random request, weighted towards small delays so entries fire soon.
  task automatic random_request();
    logic [1:0]  cmd;
    logic [31:0] dly;
    logic [31:0] per;
    logic [30:0] cid;
    int unsigned pick;
    int unsigned back;
    pick = $urandom_range(99);
    if (pick < 42)      cmd = dotq_pkg::CmdPost;
    else if (pick < 57) cmd = dotq_pkg::CmdCancel;
    else if (pick < 97) cmd = dotq_pkg::CmdTick;
    else                cmd = CmdIgnored;

    pick = $urandom_range(99);
    if (pick < 55)      dly = $urandom_range(6);
    else if (pick < 65) dly = '1;
    else if (pick < 70) dly = $urandom | 32'h8000_0000;
    else if (pick < 82) dly = $urandom_range(2000);
    else if (pick < 88) dly = 32'h7FFF_FFFF - $urandom_range(15);
    else                dly = $urandom & 32'h7FFF_FFFF;

    pick = $urandom_range(99);
    if (pick < 58)      per = '1;
    else if (pick < 66) per = '0;
    else if (pick < 88) per = $urandom_range(1, 8);
    else                per = $urandom;

    // Mostly aim at recently issued identifiers so that cancels can hit.
    back = $urandom_range(24);
    if ($urandom_range(99) < 75)
      cid = dotq_pkg::IdStart + 31'((posts_sent > back) ? posts_sent - back : 0);
    else
      cid = 31'($urandom);

    send_req(cmd, dly, per, cid);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned items);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (items) random_request();
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Quiet tick and cancel misses on an empty queue.
    send_req(dotq_pkg::CmdTick, '1, '1, '1);
    send_req(dotq_pkg::CmdCancel, '0, '0, '0);
    send_req(dotq_pkg::CmdCancel, '1, '1, dotq_pkg::IdMax);
    // Negative delay uses an identifier but stores nothing.
    send_req(dotq_pkg::CmdPost, 32'hFFFF_FFFF, 32'd5, '0);
    send_req(CmdIgnored, 32'd3, 32'd3, dotq_pkg::IdStart);
    // A zero-period entry due now, then fifteen one-shots due next tick.
    send_req(dotq_pkg::CmdPost, 32'd0, 32'd0, '1);
    repeat (15) send_req(dotq_pkg::CmdPost, 32'd1, '1, '0);
    // Post into a full queue, even with a negative delay.
    send_req(dotq_pkg::CmdPost, 32'h8000_0000, '1, '0);
    // Sixteen entries fire on one tick; the zero-period one only once.
    send_req(dotq_pkg::CmdTick, '0, '0, '0);
    send_req(dotq_pkg::CmdCancel, '0, '0, dotq_pkg::IdStart + 31'd1);
    send_req(dotq_pkg::CmdPost, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    wait_drained();

    // Random requests under different idling patterns.
    run_phase(0, 0, PhaseItems);
    run_phase(74, 0, PhaseItems);
    run_phase(0, 74, PhaseItems);
    run_phase(17, 17, PhaseItems);

    // Long receiver hold-off while requests keep coming.
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_start <= 1'b1;
    repeat (HoldItems) random_request();
    wait_drained();

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS deadline_ordered_timer_queue_top");
    end else begin
      $display("FAIL deadline_ordered_timer_queue_top");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #25_000_000;
    $display("FAIL deadline_ordered_timer_queue_top");
    $finish;
  end

endmodule
